>>> rtl/core/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, register codes, reset values and constants of the NTC
// thermistor temperature unit.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // Averaging and ADC defaults.
  localparam int AVERAGE_COUNT_DEF = 5;
  localparam int ADC_BITS          = 12;

  // Port widths.
  localparam int SUM_W      = 15;
  localparam int TEMP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Configuration register widths.
  localparam int FS_W   = 16;
  localparam int RREF_W = 20;
  localparam int R0_W   = 20;
  localparam int T0_W   = 16;
  localparam int BETA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 3'd0,
    CFG_REF_RES    = 3'd1,
    CFG_NOM_RES    = 3'd2,
    CFG_NOM_TEMP   = 3'd3,
    CFG_BETA       = 3'd4
  } cfg_idx_t;

  localparam logic [FS_W-1:0]   FS_RST   = FS_W'((1 << ADC_BITS) - 1);
  localparam logic [RREF_W-1:0] RREF_RST = 20'd10000;
  localparam logic [R0_W-1:0]   R0_RST   = 20'd10000;
  localparam logic [T0_W-1:0]   T0_RST   = 16'd29815;
  localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;

  // Logarithm format: integer part over the fraction, Q24.
  localparam int LOG_IN_W  = 20;
  localparam int LOG_FRAC  = 24;
  localparam int LOG_TOP_W = 5;
  localparam int LOG_W     = LOG_TOP_W + LOG_FRAC;
  localparam int MANT_W    = 32;

  // Arithmetic constants.
  localparam logic [15:0]              LN2_Q16        = 16'd45426;
  localparam logic [TEMP_W-1:0]        ZERO_C_CENTI_K = 16'd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX       = 16'sd32767;
  localparam logic signed [TEMP_W-1:0] TEMP_ZERO_K    = -16'sd27315;
  localparam logic [TEMP_W:0]          TC_SAT         = 17'd60082;
  localparam logic [6:0]               CENTI          = 7'd100;

  // Per-item status that travels down the pipeline.
  typedef struct packed {
    logic inv;   // raw reading out of range
    logic lneg;  // log ratio negative
    logic dneg;  // Beta denominator zero or negative
    logic ovf;   // quotient beyond 16 bits
  } flg_t;

endpackage

>>> rtl/core/ntc_log2.sv
// ----------------------------------------------------------------------------
// ntc_log2
// Pipelined base-2 logarithm in Q24: one normalize stage, then one squaring
// stage per fraction bit.
// ----------------------------------------------------------------------------
module ntc_log2 (
  input  logic                          clk,
  input  logic [ntc_pkg::LOG_FRAC:0]    en,
  input  logic [ntc_pkg::LOG_IN_W-1:0]  x,
  output logic [ntc_pkg::LOG_W-1:0]     l
);

  localparam int NSTEP = ntc_pkg::LOG_FRAC;
  localparam int MW    = ntc_pkg::MANT_W;
  localparam int TW    = ntc_pkg::LOG_TOP_W;

  logic [ntc_pkg::LOG_IN_W-1:0] x0;
  logic [TW-1:0]                top0;
  logic [MW-1:0]                m0;

  logic [TW-1:0]    top_r  [NSTEP+1];
  logic [MW-1:0]    m_r    [NSTEP];
  logic [NSTEP-1:0] frac_r [NSTEP+1];

  logic [2*MW-1:0]  sq     [NSTEP];
  logic [MW:0]      t      [NSTEP];
  logic [MW-1:0]    m_nxt  [NSTEP];
  logic [NSTEP-1:0] frac_nxt [NSTEP];

  // Normalize: find the top set bit and move it to bit 31 (Q31 in [1,2)).
  always_comb begin
    x0   = (x == '0) ? ntc_pkg::LOG_IN_W'(1) : x;
    top0 = '0;
    for (int i = 0; i < ntc_pkg::LOG_IN_W; i++) begin
      if (x0[i]) begin
        top0 = TW'(i);
      end
    end
    m0 = MW'(x0) << (TW'(MW - 1) - top0);
  end

  // Each step squares the mantissa; an overflow past 2.0 yields a one bit.
  always_comb begin
    for (int i = 0; i < NSTEP; i++) begin
      sq[i]       = (2*MW)'(m_r[i]) * (2*MW)'(m_r[i]);
      t[i]        = sq[i][2*MW-1:MW-1];
      m_nxt[i]    = t[i][MW] ? t[i][MW:1] : t[i][MW-1:0];
      frac_nxt[i] = {frac_r[i][NSTEP-2:0], t[i][MW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      top_r[0]  <= top0;
      m_r[0]    <= m0;
      frac_r[0] <= '0;
    end
    for (int i = 0; i < NSTEP; i++) begin
      if (en[i+1]) begin
        top_r[i+1]  <= top_r[i];
        frac_r[i+1] <= frac_nxt[i];
      end
    end
    // The last step only needs its fraction bit, so the mantissa stops here.
    for (int i = 0; i < NSTEP - 1; i++) begin
      if (en[i+1]) begin
        m_r[i+1] <= m_nxt[i];
      end
    end
  end

  assign l = {top_r[NSTEP], frac_r[NSTEP]};

endmodule

>>> rtl/core/ntc_thermistor_temperature_unit.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_unit
// Converts a summed thermistor ADC reading into hundredths of a degree
// Celsius with the Beta equation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one sample sum per transfer;
// the result channel (out_valid/out_ready) returns one temperature and a
// range flag per transfer, in input order. The cfg_ port writes the five
// coefficient registers. The user must write them only while no item is in
// flight; the block does not enforce it. An item passes 50 register stages:
// one for the average (loaded by the transfer itself), 25 for the four
// parallel logarithms (one normalize stage and one squaring multiplier per
// fraction bit), seven for the Beta denominator and the dividend, and 17 for
// the rounding division (one quotient bit per stage) and output register.
// Throughput is one item per cycle while the receiver takes results. Reset
// (synchronous, rst_n low) empties the pipeline and loads the default
// coefficients. When the receiver stalls, the pipeline compacts: each stage
// moves while anything ahead of it has room, so new items are taken until
// every stage holds one; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_unit #(
  parameter int AVERAGE_COUNT = ntc_pkg::AVERAGE_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [ntc_pkg::SUM_W-1:0]              in_sample_sum,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0]      out_temp_centi_c,
  output logic                                   out_valid_res
);

  // Widths of the datapath.
  localparam int SUM_W   = ntc_pkg::SUM_W;
  localparam int RAW_MAX = ((1 << SUM_W) - 1) / AVERAGE_COUNT;
  localparam int RAW_W   = $clog2(RAW_MAX + 1);
  localparam int FS_W    = ntc_pkg::FS_W;
  localparam int LOG_W   = ntc_pkg::LOG_W;
  localparam int MAG_W   = LOG_W + 1;
  localparam int PP_W    = MAG_W + 16;
  localparam int PSUM_W  = MAG_W + 33;
  localparam int P_W     = PSUM_W - 16;
  localparam int BD_W    = 21;
  localparam int NUM_W   = BD_W + ntc_pkg::T0_W;
  localparam int D0_W    = BD_W + ntc_pkg::LOG_FRAC;
  localparam int D_W     = P_W + 2;
  localparam int DM_W    = D_W - 1;
  localparam int N_W     = NUM_W + ntc_pkg::LOG_FRAC + 1;
  localparam int DIV_STEPS = ntc_pkg::TEMP_W;
  localparam int DIV_W   = DM_W + DIV_STEPS;

  // The average is a multiply by a rounded-up reciprocal and a shift. With
  // the shift at SUM_W plus the bits of the count, the truncated quotient is
  // exact for every SUM_W-bit sum.
  localparam int     AVG_SH = SUM_W + $clog2(AVERAGE_COUNT);
  localparam int     RCP_W  = SUM_W + 1;
  localparam int     AVG_W  = SUM_W + RCP_W;
  localparam longint AVG_RCP =
    ((longint'(1) << AVG_SH) + longint'(AVERAGE_COUNT) - 1) / longint'(AVERAGE_COUNT);

  // Pipeline stage positions.
  localparam int ST_RAW  = 0;
  localparam int ST_LOG0 = 1;
  localparam int ST_LOGN = ST_LOG0 + ntc_pkg::LOG_FRAC;
  localparam int ST_SUM  = ST_LOGN + 1;
  localparam int ST_MAG  = ST_SUM + 1;
  localparam int ST_PP   = ST_MAG + 1;
  localparam int ST_P    = ST_PP + 1;
  localparam int ST_D    = ST_P + 1;
  localparam int ST_N    = ST_D + 1;
  localparam int ST_OVF  = ST_N + 1;
  localparam int ST_DIV0 = ST_OVF + 1;
  localparam int ST_OUT  = ST_DIV0 + DIV_STEPS;
  localparam int NSTG    = ST_OUT + 1;

  // Configuration registers and values derived from them.
  logic [FS_W-1:0]             fs_r;
  logic [ntc_pkg::RREF_W-1:0]  rref_r;
  logic [ntc_pkg::R0_W-1:0]    r0_r;
  logic [ntc_pkg::T0_W-1:0]    t0_r;
  logic [ntc_pkg::BETA_W-1:0]  beta_r;
  logic [FS_W-1:0]             fs_eff;
  logic [ntc_pkg::RREF_W-1:0]  rref_eff;
  logic [ntc_pkg::R0_W-1:0]    r0_eff;
  logic [ntc_pkg::T0_W-1:0]    t0_eff;
  logic [ntc_pkg::BETA_W-1:0]  beta_eff;
  logic [31:0]                 k_r;
  logic [BD_W-1:0]             bd_r;
  logic [NUM_W-1:0]            num_r;

  // Flow control.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] full_mask;

  ntc_pkg::flg_t flg_r   [ST_OUT];
  ntc_pkg::flg_t flg_nxt [ST_OUT];

  // Stage data.
  logic [AVG_W-1:0]  avg_prod;
  logic [SUM_W-1:0]  quo;
  logic [RAW_W-1:0]  raw0;
  logic [RAW_W-1:0]  raw_r;
  logic [FS_W-1:0]   fsr_r;
  logic [LOG_W-1:0]  l_rref, l_raw, l_fsr, l_r0;
  logic [MAG_W-1:0]  pos_r, neg_r, mag_r;
  logic [PP_W-1:0]   pl_r, ph_r;
  logic [PSUM_W-1:0] psum;
  logic [P_W-1:0]    p_r;
  logic [D_W-1:0]    d_nxt;
  logic [DM_W-1:0]   d_r, dn_r;
  logic [N_W-1:0]    n_r;
  logic [DIV_W-1:0]  rem_r   [DIV_STEPS];
  logic [DM_W-1:0]   dv_r    [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r  [DIV_STEPS+1];
  logic [DIV_W-1:0]  trial   [DIV_STEPS];
  logic [DIV_STEPS-1:0] ge;
  logic [DIV_W-1:0]  rem_nxt [DIV_STEPS];

  logic [ntc_pkg::TEMP_W-1:0]        tc;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_nxt;
  logic                              res_nxt;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_r;
  logic                              res_r;

  // ---------------------------------------------------------------------------
  // Configuration. A register that holds zero behaves as one.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= ntc_pkg::FS_RST;
      rref_r <= ntc_pkg::RREF_RST;
      r0_r   <= ntc_pkg::R0_RST;
      t0_r   <= ntc_pkg::T0_RST;
      beta_r <= ntc_pkg::BETA_RST;
    end else if (cfg_we) begin
      unique case (ntc_pkg::cfg_idx_t'(cfg_index))
        ntc_pkg::CFG_FULL_SCALE: fs_r   <= cfg_wdata[FS_W-1:0];
        ntc_pkg::CFG_REF_RES:    rref_r <= cfg_wdata[ntc_pkg::RREF_W-1:0];
        ntc_pkg::CFG_NOM_RES:    r0_r   <= cfg_wdata[ntc_pkg::R0_W-1:0];
        ntc_pkg::CFG_NOM_TEMP:   t0_r   <= cfg_wdata[ntc_pkg::T0_W-1:0];
        ntc_pkg::CFG_BETA:       beta_r <= cfg_wdata[ntc_pkg::BETA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign fs_eff   = (fs_r   == '0) ? FS_W'(1) : fs_r;
  assign rref_eff = (rref_r == '0) ? ntc_pkg::RREF_W'(1) : rref_r;
  assign r0_eff   = (r0_r   == '0) ? ntc_pkg::R0_W'(1) : r0_r;
  assign t0_eff   = (t0_r   == '0) ? ntc_pkg::T0_W'(1) : t0_r;
  assign beta_eff = (beta_r == '0) ? ntc_pkg::BETA_W'(1) : beta_r;

  // Coefficient products; num_r is registered from bd_r. They settle well
  // before any item reaches the stages that use them.
  always_ff @(posedge clk) begin
    k_r   <= 32'(t0_eff) * 32'(ntc_pkg::LN2_Q16);
    bd_r  <= BD_W'(beta_eff) * BD_W'(ntc_pkg::CENTI);
    num_r <= NUM_W'(t0_eff) * NUM_W'(bd_r);
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage loads when it is empty or when some stage ahead
  // of it, or the receiver, makes room, so bubbles close up under a stall.
  // ---------------------------------------------------------------------------
  always_comb begin
    full_mask = '0;
    for (int s = 0; s < NSTG; s++) begin
      full_mask = {NSTG{1'b1}} << s;
      en[s]     = out_ready || ((v_r & full_mask) != full_mask);
    end
  end

  assign in_ready = en[ST_RAW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[ST_RAW]) begin
        v_r[ST_RAW] <= in_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: average by reciprocal multiplication, and range check.
  // fs - raw feeds the divider logarithm.
  // ---------------------------------------------------------------------------
  always_comb begin
    avg_prod = AVG_W'(in_sample_sum) * AVG_W'(AVG_RCP);
    quo      = SUM_W'(avg_prod >> AVG_SH);
    raw0     = quo[RAW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_RAW]) begin
      raw_r <= raw0;
      fsr_r <= fs_eff - FS_W'(raw0);
    end
  end

  // ---------------------------------------------------------------------------
  // Status flags travel with each item and are set where they arise.
  // ---------------------------------------------------------------------------
  always_comb begin
    flg_nxt[ST_RAW]      = '0;
    flg_nxt[ST_RAW].inv  = (raw0 == '0) || (FS_W'(raw0) >= fs_eff);
    for (int s = 1; s < ST_OUT; s++) begin
      flg_nxt[s] = flg_r[s-1];
    end
    flg_nxt[ST_MAG].lneg = neg_r > pos_r;
    flg_nxt[ST_D].dneg   = d_nxt[D_W-1] || (d_nxt == '0);
    flg_nxt[ST_OVF].ovf  = DIV_W'(n_r) >= {dn_r, DIV_STEPS'(0)};
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ST_OUT; s++) begin
      if (en[s]) begin
        flg_r[s] <= flg_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Four logarithms in parallel.
  // ---------------------------------------------------------------------------
  ntc_log2 u_log_rref (
    .clk (clk),
    .en  (en[ST_LOGN:ST_LOG0]),
    .x   (rref_eff),
    .l   (l_rref)
  );

  ntc_log2 u_log_raw (
    .clk (clk),
    .en  (en[ST_LOGN:ST_LOG0]),
    .x   (ntc_pkg::LOG_IN_W'(raw_r)),
    .l   (l_raw)
  );

  ntc_log2 u_log_fsr (
    .clk (clk),
    .en  (en[ST_LOGN:ST_LOG0]),
    .x   (ntc_pkg::LOG_IN_W'(fsr_r)),
    .l   (l_fsr)
  );

  ntc_log2 u_log_r0 (
    .clk (clk),
    .en  (en[ST_LOGN:ST_LOG0]),
    .x   (r0_eff),
    .l   (l_r0)
  );

  // ---------------------------------------------------------------------------
  // log2(R/R0) = log2(Rref) + log2(raw) - log2(fs - raw) - log2(R0), split
  // into a magnitude and a sign, then scaled by T0 * ln 2.
  // ---------------------------------------------------------------------------
  always_comb begin
    psum  = PSUM_W'(pl_r) + (PSUM_W'(ph_r) << 16) + (PSUM_W'(1) << 15);
    d_nxt = flg_r[ST_P].lneg ? D_W'({bd_r, ntc_pkg::LOG_FRAC'(0)}) - D_W'(p_r)
                             : D_W'({bd_r, ntc_pkg::LOG_FRAC'(0)}) + D_W'(p_r);
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      pos_r <= MAG_W'(l_rref) + MAG_W'(l_raw);
      neg_r <= MAG_W'(l_fsr) + MAG_W'(l_r0);
    end
    if (en[ST_MAG]) begin
      mag_r <= (neg_r > pos_r) ? neg_r - pos_r : pos_r - neg_r;
    end
    // The 30 x 32 product is taken as two 30 x 16 halves.
    if (en[ST_PP]) begin
      pl_r <= PP_W'(mag_r) * PP_W'(k_r[15:0]);
      ph_r <= PP_W'(mag_r) * PP_W'(k_r[31:16]);
    end
    if (en[ST_P]) begin
      p_r <= psum[PSUM_W-1:16];
    end
    // Denominator 100*Beta*2^24 +/- P. A zero or negative value is flagged and saturates.
    if (en[ST_D]) begin
      d_r <= d_nxt[DM_W-1:0];
    end
    // Dividend with half the divisor added for rounding.
    if (en[ST_N]) begin
      n_r  <= N_W'({num_r, ntc_pkg::LOG_FRAC'(0)}) + N_W'(d_r >> 1);
      dn_r <= d_r;
    end
    if (en[ST_OVF]) begin
      rem_r[0] <= DIV_W'(n_r);
      dv_r[0]  <= dn_r;
      q_r[0]   <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring division, one quotient bit per stage, most significant first.
  // An item flagged as overflowed saturates, so only 16 bits are needed.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial[j]   = DIV_W'(dv_r[j]) << (DIV_STEPS - 1 - j);
      ge[j]      = rem_r[j] >= trial[j];
      rem_nxt[j] = ge[j] ? rem_r[j] - trial[j] : rem_r[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en[ST_DIV0+j]) begin
        q_r[j+1] <= {q_r[j][DIV_STEPS-2:0], ge[j]};
      end
    end
    // The last step only produces its quotient bit.
    for (int j = 0; j < DIV_STEPS - 1; j++) begin
      if (en[ST_DIV0+j]) begin
        rem_r[j+1] <= rem_nxt[j];
        dv_r[j+1]  <= dv_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: convert kelvin to Celsius and saturate; an out-of-range reading reports absolute zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    tc = q_r[DIV_STEPS];
    if (flg_r[ST_OUT-1].inv) begin
      temp_nxt = ntc_pkg::TEMP_ZERO_K;
      res_nxt  = 1'b0;
    end else if (flg_r[ST_OUT-1].dneg || flg_r[ST_OUT-1].ovf ||
                 ({1'b0, tc} >= ntc_pkg::TC_SAT)) begin
      temp_nxt = ntc_pkg::TEMP_MAX;
      res_nxt  = 1'b1;
    end else begin
      temp_nxt = signed'(tc - ntc_pkg::ZERO_C_CENTI_K);
      res_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      temp_r <= temp_nxt;
      res_r  <= res_nxt;
    end
  end

  assign out_valid        = v_r[ST_OUT];
  assign out_temp_centi_c = temp_r;
  assign out_valid_res    = res_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An out-of-range reading always reports absolute zero.
  a_invalid_zero_k: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_temp_centi_c == ntc_pkg::TEMP_ZERO_K)
    else $error("out-of-range result is not absolute zero");

  // A valid temperature never lies below absolute zero.
  a_above_zero_k: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_temp_centi_c >= ntc_pkg::TEMP_ZERO_K)
    else $error("temperature below absolute zero");

  // The input is refused only when every stage holds an item.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r == {NSTG{1'b1}}) && !out_ready)
    else $error("input refused while the pipeline has room");

  // An item in the last division stage moves into the output register.
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_OUT-1] && en[ST_OUT] |=> out_valid)
    else $error("item lost between division and output register");

endmodule
